// File: design/cllp_pkg.sv
// Shared types and constants for the cursor linked list pool.
// Holds the pool geometry, operation and status codes, the controller states
// and the link table write request. Depends on nothing.
package cllp_pkg;

	localparam int SLOTS     = 8;
	localparam int SLOT_W    = $clog2(SLOTS);
	localparam int HEAD_SLOT = SLOTS - 1;
	localparam int CAPACITY  = SLOTS - 2;
	localparam int OP_W      = 2;
	localparam int POS_W     = 3;
	localparam int LEN_W     = 3;
	localparam int STAT_W    = 2;
	localparam int PART_W    = 32;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_DELETE = 2'd1,
		OP_READ   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE  = 2'd0,
		ST_RANGE = 2'd1,
		ST_FULL  = 2'd2,
		ST_SPARE = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK,
		S_INS_A,
		S_INS_B,
		S_INS_C,
		S_INS_D,
		S_DEL_A,
		S_DEL_B,
		S_DEL_C,
		S_DEL_D,
		S_RD_A,
		S_RD_B,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		logic [SLOT_W-1:0] data;
	} link_wr_t;

endpackage

// File: design/cllp_link_table.sv
// Link table of the pool: one link per slot, held in flip-flops.
// Reset builds the free chain through the middle slots and an empty list.
// Depends on cllp_pkg.
module cllp_link_table import cllp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [SLOT_W-1:0] rd_addr,
	output logic [SLOT_W-1:0] rd_data,
	input  link_wr_t          wr
);

	logic [SLOT_W-1:0] link_q [SLOTS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				if (i + 1 < HEAD_SLOT) begin
					link_q[i] <= SLOT_W'(i + 1);
				end else begin
					link_q[i] <= '0;
				end
			end
		end else if (wr.en) begin
			link_q[wr.addr] <= wr.data;
		end
	end

	assign rd_data = link_q[rd_addr];

endmodule

// File: design/cursor_linked_list_pool.sv
// Top level of the cursor linked list pool: controller, value store and result register.
// Uses cllp_pkg and cllp_link_table.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_stall  | op, position, real_part, imag_part
//  out     | out_valid / out_stall| status, value_real, value_imag, list_length
//
// One request at a time; the link table is read once per cycle, one link per step of the walk.
// The result register lets a request be taken while the previous result still waits.
// A stalled result holds the controller in its last state until the result is taken.
// Reset is asynchronous and leaves an empty list with every spare slot on the free chain.
module cursor_linked_list_pool import cllp_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [OP_W-1:0]          op,
	input  logic [POS_W-1:0]         position,
	input  logic signed [PART_W-1:0] real_part,
	input  logic signed [PART_W-1:0] imag_part,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic signed [PART_W-1:0] value_real,
	output logic signed [PART_W-1:0] value_imag,
	output logic [LEN_W-1:0]         list_length
);

	state_t                state_q, state_d;
	op_t                   op_q;
	logic [POS_W-1:0]      rem_q;
	logic [SLOT_W-1:0]     k_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [LEN_W-1:0]      count_q;
	status_t               stat_q;
	logic [2*PART_W-1:0]   data_q;
	logic [2*PART_W-1:0]   val_q;
	logic [2*PART_W-1:0]   rdata_q;
	logic [2*PART_W-1:0]   value_mem [SLOTS];
	logic [SLOT_W-1:0]     val_raddr;

	logic                  out_valid_q;
	logic [STAT_W-1:0]     status_q;
	logic [PART_W-1:0]     value_real_q;
	logic [PART_W-1:0]     value_imag_q;
	logic [LEN_W-1:0]      list_length_q;

	logic [SLOT_W-1:0]     lk_raddr;
	logic [SLOT_W-1:0]     lk_rdata;
	link_wr_t              lk_wr;

	logic                  accept;
	logic                  load_out;
	logic                  pos_nz;
	logic                  ins_ok;
	logic                  sel_ok;
	logic                  full;

	cllp_link_table u_links (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (lk_raddr),
		.rd_data (lk_rdata),
		.wr      (lk_wr)
	);

	assign accept   = in_valid && (state_q == S_IDLE);
	assign load_out = (state_q == S_FINISH) && (!out_valid_q || !out_stall);
	assign pos_nz   = (position != '0);
	assign full     = ({1'b0, count_q} >= (LEN_W+1)'(CAPACITY));
	assign ins_ok   = pos_nz && ({1'b0, position} <= ({1'b0, count_q} + 1'b1));
	assign sel_ok   = pos_nz && ({1'b0, position} <= {1'b0, count_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		lk_raddr  = k_q;
		lk_wr     = '0;
		val_raddr = k_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_FINISH;
					case (op)
						OP_INSERT: if (!full && ins_ok) state_d = S_WALK;
						OP_DELETE: if (sel_ok) state_d = S_WALK;
						OP_READ:   if (sel_ok) state_d = S_WALK;
						default:   state_d = S_FINISH;
					endcase
				end
			end
			S_WALK: begin
				if (rem_q == '0) begin
					case (op_q)
						OP_INSERT: state_d = S_INS_A;
						OP_DELETE: state_d = S_DEL_A;
						default:   state_d = S_RD_A;
					endcase
				end
			end
			S_INS_A: begin
				lk_raddr = '0;
				state_d  = S_INS_B;
			end
			S_INS_B: begin
				lk_raddr = slot_q;
				lk_wr    = '{en: 1'b1, addr: '0, data: lk_rdata};
				state_d  = S_INS_C;
			end
			S_INS_C: begin
				lk_wr   = '{en: 1'b1, addr: slot_q, data: lk_rdata};
				state_d = S_INS_D;
			end
			S_INS_D: begin
				lk_wr   = '{en: 1'b1, addr: k_q, data: slot_q};
				state_d = S_FINISH;
			end
			S_DEL_A: begin
				state_d = S_DEL_B;
			end
			S_DEL_B: begin
				lk_raddr  = slot_q;
				val_raddr = slot_q;
				lk_wr     = '{en: 1'b1, addr: k_q, data: lk_rdata};
				state_d   = S_DEL_C;
			end
			S_DEL_C: begin
				lk_raddr = '0;
				lk_wr    = '{en: 1'b1, addr: slot_q, data: lk_rdata};
				state_d  = S_DEL_D;
			end
			S_DEL_D: begin
				lk_wr   = '{en: 1'b1, addr: '0, data: slot_q};
				state_d = S_FINISH;
			end
			S_RD_A: begin
				state_d = S_RD_B;
			end
			S_RD_B: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (!out_valid_q || !out_stall) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != S_IDLE);

	always_ff @(posedge clk) begin
		if (state_q == S_INS_B) begin
			value_mem[slot_q] <= data_q;
		end
		rdata_q <= value_mem[val_raddr];
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					op_q   <= op_t'(op);
					data_q <= {imag_part, real_part};
					val_q  <= '0;
					k_q    <= SLOT_W'(HEAD_SLOT);
					if (op == OP_READ) begin
						rem_q <= position;
					end else begin
						rem_q <= position - 1'b1;
					end
					stat_q <= ST_RANGE;
					case (op)
						OP_INSERT: begin
							if (full) begin
								stat_q <= ST_FULL;
							end else if (ins_ok) begin
								stat_q <= ST_DONE;
							end
						end
						OP_DELETE: if (sel_ok) stat_q <= ST_DONE;
						OP_READ:   if (sel_ok) stat_q <= ST_DONE;
						default:   stat_q <= ST_RANGE;
					endcase
				end
			end
			S_WALK: begin
				if (rem_q != '0) begin
					k_q   <= lk_rdata;
					rem_q <= rem_q - 1'b1;
				end
			end
			S_INS_A: slot_q <= lk_rdata;
			S_DEL_A: slot_q <= lk_rdata;
			S_DEL_C: val_q  <= rdata_q;
			S_RD_B:  val_q  <= rdata_q;
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (state_q == S_INS_D) begin
			count_q <= count_q + 1'b1;
		end else if (state_q == S_DEL_D) begin
			count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			status_q      <= stat_q;
			value_real_q  <= val_q[PART_W-1:0];
			value_imag_q  <= val_q[2*PART_W-1:PART_W];
			list_length_q <= count_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign value_real  = value_real_q;
	assign value_imag  = value_imag_q;
	assign list_length = list_length_q;

`ifndef SYNTHESIS
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("controller stayed idle after taking a request");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		({1'b0, count_q} <= (LEN_W+1)'(CAPACITY)))
		else $error("entry count beyond capacity");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |->
		((count_q == $past(count_q) + 1'b1) || (count_q == $past(count_q) - 1'b1)))
		else $error("entry count moved by more than one");

	a_slot_distinct: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_INS_D) |-> (k_q != slot_q))
		else $error("new slot equals the predecessor slot");
`endif

endmodule

// File: verif/cursor_linked_list_pool_tb.sv
// Self-checking testbench for cursor_linked_list_pool, with directed and random requests.
// It predicts each result from its own copy of the slot links, values and count.
// Depends on cllp_pkg and the cursor_linked_list_pool RTL only.
module cursor_linked_list_pool_tb;
	import cllp_pkg::*;

	typedef struct {
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [PART_W-1:0] re;
		logic [PART_W-1:0] im;
		bit                drain;
	} list_req_t;

	typedef struct {
		status_t           status;
		logic [PART_W-1:0] vr;
		logic [PART_W-1:0] vi;
		logic [LEN_W-1:0]  len;
	} list_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [OP_W-1:0]          op = OP_INSERT;
	logic [POS_W-1:0]         position = '0;
	logic signed [PART_W-1:0] real_part = '0;
	logic signed [PART_W-1:0] imag_part = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic [STAT_W-1:0]        status;
	logic signed [PART_W-1:0] value_real;
	logic signed [PART_W-1:0] value_imag;
	logic [LEN_W-1:0]         list_length;

	cursor_linked_list_pool dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.op(op), .position(position), .real_part(real_part), .imag_part(imag_part),
		.out_valid(out_valid), .out_stall(out_stall),
		.status(status), .value_real(value_real), .value_imag(value_imag),
		.list_length(list_length)
	);

	list_req_t   request_queue[$];
	list_res_t   pending_results[$];
	logic [SLOT_W-1:0] pool_link [SLOTS];
	logic [63:0] pool_value [SLOTS];
	int unsigned pool_count;
	int unsigned plan_count;
	int          fail_count = 0;
	logic        req_taken = 1'b0;
	int unsigned burst_left = 0;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned stall_mode = 0;
	list_req_t   next_req;
	list_req_t   seen_req;
	list_res_t   got_res;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [SLOT_W-1:0] walk_links(input int unsigned steps);
		logic [SLOT_W-1:0] k;
		k = SLOT_W'(HEAD_SLOT);
		for (int unsigned j = 0; j < steps; j++)
			k = pool_link[k];
		return k;
	endfunction

	function automatic list_res_t apply_list_op(input list_req_t rq);
		list_res_t         res;
		logic [SLOT_W-1:0] k;
		logic [SLOT_W-1:0] m;
		logic [63:0]       val;
		res.status = ST_RANGE;
		val = '0;
		case (rq.op)
			OP_INSERT: begin
				if (pool_count >= CAPACITY) begin
					res.status = ST_FULL;
				end else if (rq.pos >= 1 && rq.pos <= pool_count + 1) begin
					k = walk_links(rq.pos - 1);
					m = pool_link[0];
					pool_link[0] = pool_link[m];
					pool_value[m] = {rq.im, rq.re};
					pool_link[m] = pool_link[k];
					pool_link[k] = m;
					pool_count++;
					res.status = ST_DONE;
				end
			end
			OP_DELETE: begin
				if (rq.pos >= 1 && rq.pos <= pool_count) begin
					k = walk_links(rq.pos - 1);
					m = pool_link[k];
					val = pool_value[m];
					pool_link[k] = pool_link[m];
					pool_link[m] = pool_link[0];
					pool_link[0] = m;
					pool_count--;
					res.status = ST_DONE;
				end
			end
			OP_READ: begin
				if (rq.pos >= 1 && rq.pos <= pool_count) begin
					val = pool_value[walk_links(rq.pos)];
					res.status = ST_DONE;
				end
			end
			default: ;
		endcase
		res.vr = val[31:0];
		res.vi = val[63:32];
		res.len = pool_count[LEN_W-1:0];
		return res;
	endfunction

	task automatic add_req(input op_t o, input int unsigned p, input logic [PART_W-1:0] re,
			input logic [PART_W-1:0] im, input bit drain);
		list_req_t rq;
		rq.op = o;
		rq.pos = p[POS_W-1:0];
		rq.re = re;
		rq.im = im;
		rq.drain = drain;
		request_queue.push_back(rq);
		if (o == OP_INSERT && plan_count < CAPACITY && p >= 1 && p <= plan_count + 1)
			plan_count++;
		else if (o == OP_DELETE && p >= 1 && p <= plan_count)
			plan_count--;
	endtask

	function automatic logic [PART_W-1:0] pick_part();
		case ($urandom_range(9))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return 32'hFFFF_FFFF;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: status %0d", status);
					fail_count++;
				end else begin
					got_res = pending_results.pop_front();
					if (status !== got_res.status) begin
						$error("status: expected %0d, actual %0d", got_res.status, status);
						fail_count++;
					end
					if (value_real !== got_res.vr) begin
						$error("value_real: expected %0d, actual %0d",
							$signed(got_res.vr), value_real);
						fail_count++;
					end
					if (value_imag !== got_res.vi) begin
						$error("value_imag: expected %0d, actual %0d",
							$signed(got_res.vi), value_imag);
						fail_count++;
					end
					if (list_length !== got_res.len) begin
						$error("list_length: expected %0d, actual %0d", got_res.len, list_length);
						fail_count++;
					end
				end
			end
			if (in_valid && !in_stall) begin
				seen_req.op = op_t'(op);
				seen_req.pos = position;
				seen_req.re = real_part;
				seen_req.im = imag_part;
				seen_req.drain = 1'b0;
				pending_results.push_back(apply_list_op(seen_req));
			end
			req_taken <= in_valid && !in_stall;
		end else begin
			req_taken <= 1'b0;
		end
	end

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !req_taken) begin
			in_valid <= 1'b1;
		end else if (request_queue.size() != 0 && burst_left != 0
				&& !(request_queue[0].drain && pending_results.size() != 0)) begin
			next_req = request_queue.pop_front();
			op <= next_req.op;
			position <= next_req.pos;
			real_part <= next_req.re;
			imag_part <= next_req.im;
			in_valid <= 1'b1;
			burst_left <= burst_left - 1;
		end else begin
			in_valid <= 1'b0;
			if (burst_left == 0) begin
				if (gap_left == 0) begin
					burst_left <= $urandom_range(20, 1);
					gap_left <= ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
				end else begin
					gap_left <= gap_left - 1;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(3);
			stall_left <= $urandom_range(60, 10);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(3) == 0);
			2: out_stall <= ($urandom_range(3) != 0);
			default: out_stall <= stall_left[3];
		endcase
	end

	initial begin
		#3000000;
		$display("** cursor_linked_list_pool: FAILED **");
		$finish;
	end

	initial begin
		int unsigned r;
		op_t         o;
		int unsigned p;
		for (int i = 0; i < SLOTS; i++) begin
			pool_link[i] = '0;
			pool_value[i] = '0;
		end
		for (int i = 0; i + 1 < HEAD_SLOT; i++)
			pool_link[i] = SLOT_W'(i + 1);
		pool_link[HEAD_SLOT] = '0;
		pool_count = 0;
		plan_count = 0;

		// Rejections on an empty list, then filling to capacity at the ends and the middle.
		add_req(OP_READ, 1, pick_part(), pick_part(), 0);
		add_req(OP_DELETE, 1, pick_part(), pick_part(), 0);
		add_req(OP_INSERT, 0, pick_part(), pick_part(), 0);
		add_req(OP_INSERT, 2, pick_part(), pick_part(), 0);
		add_req(OP_NONE, 3, pick_part(), pick_part(), 0);
		add_req(OP_INSERT, 1, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		add_req(OP_INSERT, 1, 32'hFFFF_FFFF, 32'h0000_0000, 0);
		add_req(OP_INSERT, 3, 32'h8000_0000, 32'h7FFF_FFFF, 0);
		add_req(OP_INSERT, 2, $urandom, $urandom, 0);
		add_req(OP_INSERT, 5, $urandom, $urandom, 0);
		add_req(OP_INSERT, 3, $urandom, $urandom, 0);
		add_req(OP_INSERT, 1, $urandom, $urandom, 0);
		add_req(OP_INSERT, 7, $urandom, $urandom, 0);
		add_req(OP_READ, 7, pick_part(), pick_part(), 0);
		add_req(OP_READ, 6, pick_part(), pick_part(), 0);
		add_req(OP_READ, 1, pick_part(), pick_part(), 0);
		add_req(OP_NONE, 0, pick_part(), pick_part(), 0);
		add_req(OP_DELETE, 6, pick_part(), pick_part(), 0);
		add_req(OP_DELETE, 1, pick_part(), pick_part(), 0);
		add_req(OP_DELETE, 2, pick_part(), pick_part(), 0);
		add_req(OP_READ, 0, pick_part(), pick_part(), 0);
		add_req(OP_DELETE, 0, pick_part(), pick_part(), 0);
		add_req(OP_INSERT, 4, pick_part(), pick_part(), 0);
		add_req(OP_READ, 4, pick_part(), pick_part(), 0);

		for (int i = 0; i < 700; i++) begin
			r = $urandom_range(99);
			if (r < 8) begin
				o = op_t'($urandom_range(3));
				p = $urandom_range(7);
			end else begin
				r = $urandom_range(99);
				if (plan_count == 0)
					o = (r < 85) ? OP_INSERT : op_t'($urandom_range(2, 1));
				else if (plan_count == CAPACITY)
					o = (r < 15) ? OP_INSERT : ((r < 60) ? OP_DELETE : OP_READ);
				else
					o = (r < 38) ? OP_INSERT : ((r < 68) ? OP_DELETE : OP_READ);
				if (o == OP_INSERT)
					p = $urandom_range(plan_count + 1, 1);
				else
					p = (plan_count == 0) ? 1 : $urandom_range(plan_count, 1);
			end
			add_req(o, p, pick_part(), pick_part(), (i == 0) || (i == 350));
		end

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (request_queue.size() != 0 || in_valid)
			@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0)
			$display("** cursor_linked_list_pool: PASSED **");
		else
			$display("** cursor_linked_list_pool: FAILED **");
		$finish;
	end

endmodule
